FILE: rtl/core/cqs_pkg.sv
// ----------------------------------------------------------------------------
// cqs_pkg
// shared sizes, codes and controller/datapath interface types for the
// compacting queue with search
// ----------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // result selection handed from controller to datapath
    typedef enum logic [2:0] {
        RES_NONE     = 3'd0,
        RES_OK_ZERO  = 3'd1,
        RES_OK_DATA  = 3'd2,
        RES_EMPTY    = 3'd3,
        RES_FULL     = 3'd4,
        RES_NOTFOUND = 3'd5
    } res_t;

    typedef struct packed {
        logic load;
        logic rd_head;
        logic rd_ptr;
        logic ptr_inc;
        logic compact_wr;
        logic compact_end;
        logic append;
        logic head_inc;
        res_t res;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic at_end;
        logic scan_done;
        logic match;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/cqs_datapath.sv
// ----------------------------------------------------------------------------
// cqs_datapath
// slot memory, head/tail indices, scan pointer and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cqs_pkg::cmd_t                     in_cmd,
    input  wire logic signed [cqs_pkg::DATA_W-1:0] in_value,
    input  wire logic signed [cqs_pkg::DATA_W-1:0] in_key,
    input  wire cqs_pkg::dp_cmd_t                  ctl,
    output cqs_pkg::dp_stat_t                      stat,
    output cqs_pkg::status_t                       out_status,
    output logic signed [cqs_pkg::DATA_W-1:0]      out_data,
    output logic                                   out_full,
    output logic                                   out_empty
);

    logic signed [cqs_pkg::DATA_W-1:0] mem [cqs_pkg::DEPTH];

    cqs_pkg::cmd_t                     cmd_reg;
    logic signed [cqs_pkg::DATA_W-1:0] value_reg;
    logic signed [cqs_pkg::DATA_W-1:0] key_reg;
    logic signed [cqs_pkg::DATA_W-1:0] rd_data_reg;
    logic [cqs_pkg::CNT_W-1:0]         head_reg, head_next;
    logic [cqs_pkg::CNT_W-1:0]         tail_reg, tail_next;
    logic [cqs_pkg::CNT_W-1:0]         ptr_reg;
    logic [cqs_pkg::CNT_W-1:0]         dst_reg;
    cqs_pkg::status_t                  res_status_reg;
    logic signed [cqs_pkg::DATA_W-1:0] res_data_reg;
    cqs_pkg::status_t                  out_status_reg;
    logic signed [cqs_pkg::DATA_W-1:0] out_data_reg;
    logic                              out_full_reg;
    logic                              out_empty_reg;
    logic                              full_now;
    logic                              empty_now;

    assign full_now  = (head_reg == '0) &&
                       (tail_reg == cqs_pkg::CNT_W'(cqs_pkg::DEPTH));
    assign empty_now = (head_reg >= tail_reg);

    assign stat.cmd       = cmd_reg;
    assign stat.full      = full_now;
    assign stat.empty     = empty_now;
    assign stat.at_end    = (tail_reg == cqs_pkg::CNT_W'(cqs_pkg::DEPTH));
    assign stat.scan_done = (ptr_reg >= tail_reg);
    assign stat.match     = (rd_data_reg == key_reg);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctl.compact_end) begin
            head_next = '0;
            tail_next = dst_reg;
        end else if (ctl.append) begin
            tail_next = tail_reg + 1'b1;
        end
        if (ctl.head_inc) begin
            head_next = head_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctl.compact_wr) begin
            mem[dst_reg[cqs_pkg::ADDR_W-1:0]] <= rd_data_reg;
        end else if (ctl.append) begin
            mem[tail_reg[cqs_pkg::ADDR_W-1:0]] <= value_reg;
        end
        if (ctl.rd_head) begin
            rd_data_reg <= mem[head_reg[cqs_pkg::ADDR_W-1:0]];
        end else if (ctl.rd_ptr) begin
            rd_data_reg <= mem[ptr_reg[cqs_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg   <= in_cmd;
            value_reg <= in_value;
            key_reg   <= in_key;
            ptr_reg   <= head_reg;
            dst_reg   <= '0;
        end else begin
            if (ctl.ptr_inc || ctl.compact_wr) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (ctl.compact_wr) begin
                dst_reg <= dst_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (ctl.res)
            cqs_pkg::RES_NONE: begin
            end
            cqs_pkg::RES_OK_ZERO: begin
                res_status_reg <= cqs_pkg::ST_OK;
                res_data_reg   <= '0;
            end
            cqs_pkg::RES_OK_DATA: begin
                res_status_reg <= cqs_pkg::ST_OK;
                res_data_reg   <= rd_data_reg;
            end
            cqs_pkg::RES_EMPTY: begin
                res_status_reg <= cqs_pkg::ST_EMPTY;
                res_data_reg   <= '0;
            end
            cqs_pkg::RES_FULL: begin
                res_status_reg <= cqs_pkg::ST_FULL;
                res_data_reg   <= '0;
            end
            cqs_pkg::RES_NOTFOUND: begin
                res_status_reg <= cqs_pkg::ST_NOTFOUND;
                res_data_reg   <= '0;
            end
            default: begin
            end
        endcase
    end

    // flags reflect the indices after the request has finished
    always_ff @(posedge aclk) begin
        if (ctl.publish) begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_full_reg   <= full_now;
            out_empty_reg  <= empty_now;
        end
    end

    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_full   = out_full_reg;
    assign out_empty  = out_empty_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cqs_ctrl.sv
// ----------------------------------------------------------------------------
// cqs_ctrl
// sequencer for insert, compaction, front access and linear search
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire cqs_pkg::dp_stat_t stat,
    output cqs_pkg::dp_cmd_t       ctl
);

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        COMPACT_RD,
        COMPACT_WR,
        APPEND,
        FRONT,
        SRCH_RD,
        SRCH_CMP,
        RESP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next  = state_reg;
        ctl         = '0;
        ctl.res     = cqs_pkg::RES_NONE;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = DISPATCH;
                end
            end
            DISPATCH: begin
                if (stat.cmd == cqs_pkg::CMD_INSERT) begin
                    if (stat.full) begin
                        ctl.res    = cqs_pkg::RES_FULL;
                        state_next = RESP;
                    end else if (stat.at_end) begin
                        state_next = COMPACT_RD;
                    end else begin
                        state_next = APPEND;
                    end
                end else if (stat.empty) begin
                    ctl.res    = cqs_pkg::RES_EMPTY;
                    state_next = RESP;
                end else if (stat.cmd == cqs_pkg::CMD_SEARCH) begin
                    state_next = SRCH_RD;
                end else begin
                    ctl.rd_head = 1'b1;
                    state_next  = FRONT;
                end
            end
            COMPACT_RD: begin
                // move live entries down to slot zero, one per read/write pair
                if (stat.scan_done) begin
                    ctl.compact_end = 1'b1;
                    state_next      = APPEND;
                end else begin
                    ctl.rd_ptr = 1'b1;
                    state_next = COMPACT_WR;
                end
            end
            COMPACT_WR: begin
                ctl.compact_wr = 1'b1;
                state_next     = COMPACT_RD;
            end
            APPEND: begin
                ctl.append = 1'b1;
                ctl.res    = cqs_pkg::RES_OK_ZERO;
                state_next = RESP;
            end
            FRONT: begin
                ctl.res      = cqs_pkg::RES_OK_DATA;
                ctl.head_inc = (stat.cmd == cqs_pkg::CMD_REMOVE);
                state_next   = RESP;
            end
            SRCH_RD: begin
                if (stat.scan_done) begin
                    ctl.res    = cqs_pkg::RES_NOTFOUND;
                    state_next = RESP;
                end else begin
                    ctl.rd_ptr = 1'b1;
                    state_next = SRCH_CMP;
                end
            end
            SRCH_CMP: begin
                if (stat.match) begin
                    ctl.res    = cqs_pkg::RES_OK_DATA;
                    state_next = RESP;
                end else begin
                    ctl.ptr_inc = 1'b1;
                    state_next  = SRCH_RD;
                end
            end
            RESP: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    ctl.publish = 1'b1;
                    state_next  = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb begin
        if (ctl.publish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/compacting_queue_with_search_unit.sv
// ----------------------------------------------------------------------------
// compacting_queue_with_search_unit
// bounded fifo of signed words with insert, remove, peek and key search
// ----------------------------------------------------------------------------
// One request is handled at a time; every request returns exactly one result
// with a status, a data word and the full/empty flags after the request.
// The sequencer walks the slot memory one entry at a time. A search reads and
// compares the live entries from the front until it finds a match or passes
// the rear. An insert that finds the rear at the end of the array with room at
// the front first compacts the live entries to slot zero, with a read and a
// write per entry, and then appends.
// A new request can be accepted as soon as a result is registered, even
// while that result still waits on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_queue_with_search_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // value[31:0], search_key[63:32]
    input  wire logic [1:0]  s_tuser,  // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // data_out[31:0], is_full[32], is_empty[33]
    output logic [1:0]       m_tuser   // status[1:0]
);

    cqs_pkg::dp_cmd_t                  ctl;
    cqs_pkg::dp_stat_t                 stat;
    cqs_pkg::status_t                  out_status;
    logic signed [cqs_pkg::DATA_W-1:0] out_data;
    logic                              out_full;
    logic                              out_empty;

    cqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    cqs_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (cqs_pkg::cmd_t'(s_tuser)),
        .in_value   (s_tdata[31:0]),
        .in_key     (s_tdata[63:32]),
        .ctl        (ctl),
        .stat       (stat),
        .out_status (out_status),
        .out_data   (out_data),
        .out_full   (out_full),
        .out_empty  (out_empty)
    );

    assign m_tdata = {6'b0, out_empty, out_full, out_data};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives compacting_queue_with_search_unit with directed and random requests
// (insert, remove, peek, search) and checks every result against a mirror of
// the queue kept in the testbench, with random stalls on both streams
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cqs_pkg::*;

    localparam int N_RANDOM    = 1425;
    localparam int QUIET_TAIL  = 150;
    localparam int LONG_HOLD   = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] data;
        logic              full;
        logic              empty;
    } queue_outcome_t;

    // mirror of the queue contents; predicts one outcome per accepted request
    class queue_mirror;
        logic [DATA_W-1:0] slots [DEPTH];
        logic [CNT_W-1:0]  head_idx;
        logic [CNT_W-1:0]  tail_idx;
        queue_outcome_t    awaited[$];
        int errors;
        int n_insert, n_reject, n_compact, n_remove, n_peek, n_search, n_miss, n_on_empty;

        function new();
            foreach (slots[k]) slots[k] = '0;
            head_idx = '0;
            tail_idx = '0;
            errors = 0;
            n_insert = 0; n_reject = 0; n_compact = 0; n_remove = 0;
            n_peek = 0; n_search = 0; n_miss = 0; n_on_empty = 0;
        endfunction

        function int live_count();
            return int'(tail_idx) - int'(head_idx);
        endfunction

        function logic [DATA_W-1:0] live_word(int i);
            return slots[int'(head_idx) + i];
        endfunction

        function bit full_now();
            return head_idx == '0 && int'(tail_idx) == DEPTH;
        endfunction

        function bit empty_now();
            return head_idx == tail_idx;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void take_request(cmd_t cmd, logic [DATA_W-1:0] value,
                                   logic [DATA_W-1:0] key);
            queue_outcome_t r;
            int live;
            r.status = ST_OK;
            r.data   = '0;
            if (cmd == CMD_INSERT) begin
                n_insert++;
                if (full_now()) begin
                    r.status = ST_FULL;
                    n_reject++;
                end else begin
                    // rear at the array end: slide live entries down to slot zero
                    if (int'(tail_idx) == DEPTH) begin
                        live = live_count();
                        for (int k = 0; k < live; k++)
                            slots[k] = slots[int'(head_idx) + k];
                        head_idx = '0;
                        tail_idx = CNT_W'(live);
                        n_compact++;
                    end
                    slots[int'(tail_idx)] = value;
                    tail_idx = tail_idx + 1'b1;
                end
            end else if (empty_now()) begin
                r.status = ST_EMPTY;
                n_on_empty++;
            end else if (cmd == CMD_REMOVE) begin
                r.data = slots[int'(head_idx)];
                head_idx = head_idx + 1'b1;
                n_remove++;
            end else if (cmd == CMD_PEEK) begin
                r.data = slots[int'(head_idx)];
                n_peek++;
            end else begin
                n_search++;
                r.status = ST_NOTFOUND;
                for (int k = int'(head_idx); k < int'(tail_idx); k++) begin
                    if (slots[k] == key) begin
                        r.status = ST_OK;
                        r.data = slots[k];
                        break;
                    end
                end
                if (r.status == ST_NOTFOUND) n_miss++;
            end
            r.full  = full_now();
            r.empty = empty_now();
            awaited.push_back(r);
        endfunction

        function void check_response(logic [1:0] status, logic [DATA_W-1:0] data,
                                     logic full, logic empty);
            queue_outcome_t r;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding: status %0d data_out %08h",
                       status, data);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, status);
                errors++;
            end
            if (data !== r.data) begin
                $error("data_out: expected %08h, got %08h", r.data, data);
                errors++;
            end
            if (full !== r.full) begin
                $error("is_full: expected %0b, got %0b", r.full, full);
                errors++;
            end
            if (empty !== r.empty) begin
                $error("is_empty: expected %0b, got %0b", r.empty, empty);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;         // value[31:0], search_key[63:32]
    logic [1:0]  s_tuser = CMD_INSERT; // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;              // data_out[31:0], is_full[32], is_empty[33]
    logic [1:0]  m_tuser;              // status[1:0]

    queue_mirror mirror;
    bit          idle_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int          quiet_cycles = 0;

    compacting_queue_with_search_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            mirror.check_response(m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[33]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one request, hold it until accepted, then record it in the mirror
    task automatic send_request(cmd_t cmd, logic [DATA_W-1:0] value,
                                logic [DATA_W-1:0] key);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {key, value};
        do @(posedge aclk); while (!s_tready);
        mirror.take_request(cmd, value, key);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return DATA_W'($urandom_range(0, 15));
        if (roll < 20) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    // command mix follows the fill level so the queue swings between empty and full
    task automatic random_request(output cmd_t cmd, output logic [DATA_W-1:0] value,
                                  output logic [DATA_W-1:0] key);
        int n;
        int roll;
        n = mirror.live_count();
        roll = $urandom_range(0, 99);
        if (n == 0)
            cmd = roll < 70 ? CMD_INSERT : roll < 80 ? CMD_REMOVE :
                  roll < 90 ? CMD_PEEK : CMD_SEARCH;
        else if (mirror.full_now())
            cmd = roll < 15 ? CMD_INSERT : roll < 55 ? CMD_REMOVE :
                  roll < 70 ? CMD_PEEK : CMD_SEARCH;
        else
            cmd = roll < 40 ? CMD_INSERT : roll < 65 ? CMD_REMOVE :
                  roll < 75 ? CMD_PEEK : CMD_SEARCH;
        value = pick_word();
        roll = $urandom_range(0, 99);
        if (n > 0 && roll < 60)
            key = mirror.live_word($urandom_range(0, n - 1));
        else
            key = pick_word();
    endtask

    initial begin
        cmd_t              cmd;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] key;

        mirror = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reads of an empty queue
        send_request(CMD_PEEK,   $urandom, $urandom);
        send_request(CMD_REMOVE, $urandom, $urandom);
        send_request(CMD_SEARCH, $urandom, $urandom);
        // fill with extreme words, one duplicated
        send_request(CMD_INSERT, 32'h8000_0000, $urandom);
        send_request(CMD_INSERT, 32'h7fff_ffff, $urandom);
        send_request(CMD_INSERT, 32'h0000_0000, $urandom);
        send_request(CMD_INSERT, 32'hffff_ffff, $urandom);
        send_request(CMD_INSERT, 32'h0000_0001, $urandom);
        send_request(CMD_INSERT, 32'h5555_5555, $urandom);
        send_request(CMD_INSERT, 32'haaaa_aaaa, $urandom);
        send_request(CMD_INSERT, 32'h8000_0000, $urandom);
        // insert into a full queue is dropped
        send_request(CMD_INSERT, 32'h1234_5678, $urandom);
        send_request(CMD_SEARCH, $urandom, 32'h8000_0000);
        send_request(CMD_SEARCH, $urandom, 32'haaaa_aaaa);
        send_request(CMD_SEARCH, $urandom, 32'h1234_5678);
        send_request(CMD_PEEK,   $urandom, $urandom);
        send_request(CMD_REMOVE, $urandom, $urandom);
        send_request(CMD_REMOVE, $urandom, $urandom);
        send_request(CMD_REMOVE, $urandom, $urandom);
        // rear at the end with room in front: compaction before append
        send_request(CMD_INSERT, 32'hdead_beef, $urandom);
        send_request(CMD_INSERT, 32'h0000_0000, $urandom);
        send_request(CMD_SEARCH, $urandom, 32'h0000_0000);
        send_request(CMD_REMOVE, $urandom, $urandom);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - QUIET_TAIL) idle_on = 1'b0;
            if (i == 300) long_hold_req = 1'b1;
            if (i == 700) begin
                // let the pipeline run dry before continuing
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (mirror.pending() != 0);
            end
            random_request(cmd, value, key);
            send_request(cmd, value, key);
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (mirror.pending() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("ran %0d inserts (%0d dropped on full, %0d with compaction), %0d removes, %0d peeks",
                 mirror.n_insert, mirror.n_reject, mirror.n_compact, mirror.n_remove,
                 mirror.n_peek);
        $display("%0d searches (%0d without a match), %0d reads of an empty queue, %0d errors",
                 mirror.n_search, mirror.n_miss, mirror.n_on_empty, mirror.errors);
        if (mirror.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
